@@ hdl/tracker_row_to_midi_events_defines.svh @@
// assertion helpers for the midi event encoder
// both expect clk and rst_n in the enclosing scope
`ifndef TRACKER_ROW_TO_MIDI_EVENTS_DEFINES_SVH
`define TRACKER_ROW_TO_MIDI_EVENTS_DEFINES_SVH

// same-cycle implication
`define TRME_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/trme_pkg.sv @@
package trme_pkg;

    localparam int TIME_W  = 28;
    localparam int DIV_W   = 11;
    localparam int QUO_W   = 26;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_VAL_W = 10;

    localparam logic [QUO_W-1:0] USEC_PER_MINUTE = 26'd60000000;
    localparam logic [23:0]      TEMPO_MAX       = 24'hFFFFFF;
    localparam logic [9:0]       TEMPO_RESET     = 10'd120;
    localparam logic [7:0]       NO_NOTE         = 8'hFF;

    // status nibbles and meta bytes
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_PROGRAM  = 4'hC;
    localparam logic [7:0] META_STATUS   = 8'hFF;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_TEMPO_LEN = 8'h03;
    localparam logic [7:0] META_EOT      = 8'h2F;

    // effect codes
    localparam logic [7:0] EFF_NOTE_OFF    = 8'd1;
    localparam logic [7:0] EFF_TEMPO_UP    = 8'd4;
    localparam logic [7:0] EFF_TEMPO_DOWN  = 8'd5;
    localparam logic [7:0] EFF_TEMPO_TWICE = 8'd6;
    localparam logic [7:0] EFF_TEMPO_HALF  = 8'd7;
    localparam logic [7:0] EFF_PROGRAM     = 8'd9;

    localparam logic OP_ROW   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO   = 2'd1;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] beat_time;
        logic [7:0]        note_code;
        logic [6:0]        velocity;
        logic [7:0]        effect_code;
        logic [7:0]        effect_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

endpackage

@@ hdl/trme_ifs.sv @@
interface trme_row_if;
    import trme_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trme_byte_if;
    import trme_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trme_cfg_if;
    import trme_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

@@ hdl/tracker_row_to_midi_events.sv @@
// tracker row to midi byte stream encoder
// after the row transaction the output segments are loaded, first running the 26-step
// serial divider when a tempo effect needs it; bytes then go out one per cycle while midi.ready is high
// a new row is accepted only once the previous row's last byte has gone; 0 to 18 bytes per row
// reset: channel 0, base tempo 120, no note sounding, event time 0; no memory to clear
`include "tracker_row_to_midi_events_defines.svh"

module tracker_row_to_midi_events (
    input  logic         clk,
    input  logic         rst_n,
    trme_cfg_if.sink     cfg,
    trme_row_if.sink     row,
    trme_byte_if.source  midi
);
    import trme_pkg::*;

    // configuration
    logic [3:0]        chan_reg;
    logic [9:0]        base_reg;

    // track state
    logic [7:0]        snd_reg;
    logic [TIME_W-1:0] time_reg;

    // latched row
    logic              op_reg;
    logic [TIME_W-1:0] beat_reg;
    logic [7:0]        code_reg;
    logic [6:0]        vel_reg;
    logic [7:0]        eff_reg;
    logic [7:0]        val_reg;
    logic              sat_reg;

    state_t            state_reg;

    // output segments, each shifted out from its top byte
    logic [31:0]       dl_sr_reg;
    logic [2:0]        dl_cnt_reg;
    logic [47:0]       ef_sr_reg;
    logic [2:0]        ef_cnt_reg;
    logic              zr_reg;
    logic [55:0]       nt_sr_reg;
    logic [2:0]        nt_cnt_reg;

    logic              row_hs;
    logic              midi_hs;

    // ---------------------------------------------------------------
    // tempo divisor, formed while the row transaction happens
    // ---------------------------------------------------------------
    logic signed [11:0] bpm;
    logic               is_tempo;
    logic               bpm_pos;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;

    always_comb
    begin
        case (row.data.effect_code)
            EFF_TEMPO_UP:    bpm = $signed({2'b00, base_reg}) + $signed({4'h0, row.data.effect_value});
            EFF_TEMPO_DOWN:  bpm = $signed({2'b00, base_reg}) - $signed({4'h0, row.data.effect_value});
            EFF_TEMPO_TWICE: bpm = $signed({1'b0, base_reg, 1'b0});
            default:         bpm = $signed({3'b000, base_reg[9:1]});
        endcase
    end

    assign is_tempo  = (row.data.operation == OP_ROW)
                       && (row.data.effect_code >= EFF_TEMPO_UP)
                       && (row.data.effect_code <= EFF_TEMPO_HALF);
    assign bpm_pos   = !bpm[11] && (bpm != 12'sd0);
    assign row_hs    = row.valid && row.ready;
    assign midi_hs   = midi.valid && midi.ready;
    // zero or negative divisor saturates, no division needed
    assign div_start = row_hs && is_tempo && bpm_pos;

    trme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (bpm[DIV_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------
    // segment build from the latched row and the quotient
    // ---------------------------------------------------------------
    logic [TIME_W-1:0] delta;
    logic [31:0]       vlq_full;
    logic [2:0]        vlq_k;
    logic [31:0]       vlq_sr;
    logic [23:0]       tempo_val;
    logic              has_note;
    logic [7:0]        new_note;
    logic [7:0]        snd_mid;
    logic [7:0]        snd_after;
    logic [47:0]       ld_ef_sr;
    logic [2:0]        ld_ef_len;
    logic [55:0]       ld_nt_sr;
    logic [2:0]        ld_nt_len;
    logic              ld_zr;
    logic              ld_dl_on;

    always_comb
    begin
        delta    = beat_reg - time_reg;
        vlq_full = {1'b1, delta[27:21], 1'b1, delta[20:14], 1'b1, delta[13:7],
                    1'b0, delta[6:0]};
        // group count of the variable-length quantity
        if (delta[27:21] != '0)
            vlq_k = 3'd4;
        else if (delta[27:14] != '0)
            vlq_k = 3'd3;
        else if (delta[27:7] != '0)
            vlq_k = 3'd2;
        else
            vlq_k = 3'd1;
        case (vlq_k)
            3'd4:    vlq_sr = vlq_full;
            3'd3:    vlq_sr = {vlq_full[23:0], 8'h00};
            3'd2:    vlq_sr = {vlq_full[15:0], 16'h0000};
            default: vlq_sr = {vlq_full[7:0], 24'h000000};
        endcase

        if (sat_reg || (div_quo[QUO_W-1:24] != '0))
            tempo_val = TEMPO_MAX;
        else
            tempo_val = div_quo[23:0];

        has_note  = (code_reg != 8'h00) && (code_reg != NO_NOTE);
        new_note  = code_reg - 8'd1;
        snd_mid   = has_note ? new_note : snd_reg;
        snd_after = snd_mid;
        ld_ef_sr  = '0;
        ld_ef_len = 3'd0;
        ld_nt_sr  = '0;
        ld_nt_len = 3'd0;
        ld_zr     = 1'b0;
        ld_dl_on  = 1'b0;

        if (op_reg == OP_FLUSH)
        begin
            // note-off for a sounding note, then 00 ff 2f 00
            snd_after = NO_NOTE;
            if (snd_reg != NO_NOTE)
            begin
                ld_dl_on  = 1'b1;
                ld_ef_sr  = {STAT_NOTE_OFF, chan_reg, snd_reg, 8'h00, 24'h000000};
                ld_ef_len = 3'd3;
            end
            ld_zr     = 1'b1;
            ld_nt_sr  = {META_STATUS, META_EOT, 8'h00, 32'h00000000};
            ld_nt_len = 3'd3;
        end
        else
        begin
            if (has_note)
            begin
                if (snd_reg != NO_NOTE)
                begin
                    ld_nt_sr  = {STAT_NOTE_OFF, chan_reg, snd_reg, 8'h00, 8'h00,
                                 STAT_NOTE_ON, chan_reg, new_note, 1'b0, vel_reg};
                    ld_nt_len = 3'd7;
                end
                else
                begin
                    ld_nt_sr  = {STAT_NOTE_ON, chan_reg, new_note, 1'b0, vel_reg, 32'h00000000};
                    ld_nt_len = 3'd3;
                end
            end

            if (eff_reg == EFF_NOTE_OFF)
            begin
                // names the note of this row when there is one
                if (snd_mid != NO_NOTE)
                begin
                    ld_ef_sr  = {STAT_NOTE_OFF, chan_reg, snd_mid, 8'h00, 24'h000000};
                    ld_ef_len = 3'd3;
                    snd_after = NO_NOTE;
                end
            end
            else if ((eff_reg >= EFF_TEMPO_UP) && (eff_reg <= EFF_TEMPO_HALF))
            begin
                ld_ef_sr  = {META_STATUS, META_TEMPO, META_TEMPO_LEN, tempo_val};
                ld_ef_len = 3'd6;
            end
            else if (eff_reg == EFF_PROGRAM)
            begin
                ld_ef_sr  = {STAT_PROGRAM, chan_reg, val_reg, 32'h00000000};
                ld_ef_len = 3'd2;
            end

            ld_zr    = (ld_ef_len != 3'd0) && (ld_nt_len != 3'd0);
            ld_dl_on = (ld_ef_len != 3'd0) || (ld_nt_len != 3'd0);
        end
    end

    // ---------------------------------------------------------------
    // byte selection: delta, effect, zero delta, note, in that order
    // ---------------------------------------------------------------
    logic [7:0] cur_byte;
    logic       cur_last;

    always_comb
    begin
        if (dl_cnt_reg != 3'd0)
            cur_byte = dl_sr_reg[31:24];
        else if (ef_cnt_reg != 3'd0)
            cur_byte = ef_sr_reg[47:40];
        else if (zr_reg)
            cur_byte = 8'h00;
        else
            cur_byte = nt_sr_reg[55:48];

        cur_last = (nt_cnt_reg == 3'd1)
                   || ((nt_cnt_reg == 3'd0) && !zr_reg
                       && (((ef_cnt_reg == 3'd1) && (dl_cnt_reg == 3'd0))
                           || ((ef_cnt_reg == 3'd0) && (dl_cnt_reg == 3'd1))));
    end

    assign row.ready            = (state_reg == ST_IDLE);
    assign midi.valid           = (state_reg == ST_SEND);
    assign midi.data.midi_byte  = cur_byte;
    assign midi.data.last_byte  = cur_last;
    assign cfg.ready            = 1'b1;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= 4'h0;
            base_reg <= TEMPO_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_CHANNEL: chan_reg <= cfg.value[3:0];
                CFG_TEMPO:   base_reg <= cfg.value;
                default:     ;
            endcase
        end
    end

    // latched row payload
    always_ff @(posedge clk)
    begin
        if (row_hs)
        begin
            op_reg   <= row.data.operation;
            beat_reg <= row.data.beat_time;
            code_reg <= row.data.note_code;
            vel_reg  <= row.data.velocity;
            eff_reg  <= row.data.effect_code;
            val_reg  <= row.data.effect_value;
            sat_reg  <= !bpm_pos;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            snd_reg    <= NO_NOTE;
            time_reg   <= '0;
            dl_cnt_reg <= 3'd0;
            ef_cnt_reg <= 3'd0;
            nt_cnt_reg <= 3'd0;
            zr_reg     <= 1'b0;
            dl_sr_reg  <= '0;
            ef_sr_reg  <= '0;
            nt_sr_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (row_hs)
                        state_reg <= div_start ? ST_DIV : ST_LOAD;
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    // silent rows leave the track state untouched
                    if (ld_dl_on || (op_reg == OP_FLUSH))
                    begin
                        snd_reg    <= snd_after;
                        dl_sr_reg  <= vlq_sr;
                        dl_cnt_reg <= ld_dl_on ? vlq_k : 3'd0;
                        ef_sr_reg  <= ld_ef_sr;
                        ef_cnt_reg <= ld_ef_len;
                        zr_reg     <= ld_zr;
                        nt_sr_reg  <= ld_nt_sr;
                        nt_cnt_reg <= ld_nt_len;
                        if (ld_dl_on)
                            time_reg <= beat_reg;
                        state_reg <= ST_SEND;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_SEND:
                begin
                    if (midi_hs)
                    begin
                        if (dl_cnt_reg != 3'd0)
                        begin
                            dl_sr_reg  <= {dl_sr_reg[23:0], 8'h00};
                            dl_cnt_reg <= dl_cnt_reg - 3'd1;
                        end
                        else if (ef_cnt_reg != 3'd0)
                        begin
                            ef_sr_reg  <= {ef_sr_reg[39:0], 8'h00};
                            ef_cnt_reg <= ef_cnt_reg - 3'd1;
                        end
                        else if (zr_reg)
                            zr_reg <= 1'b0;
                        else
                        begin
                            nt_sr_reg  <= {nt_sr_reg[47:0], 8'h00};
                            nt_cnt_reg <= nt_cnt_reg - 3'd1;
                        end
                        if (cur_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `TRME_ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider finished outside the divide wait")
    `TRME_ASSERT_NEXT(a_last_frees_input, midi_hs && midi.data.last_byte, row.ready, "final byte did not release the row input")
    `TRME_ASSERT_IMPL(a_send_has_bytes, state_reg == ST_SEND, (dl_cnt_reg != 3'd0) || (ef_cnt_reg != 3'd0) || zr_reg || (nt_cnt_reg != 3'd0), "send state with no bytes left")

endmodule

@@ hdl/trme_div.sv @@
module trme_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [trme_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [trme_pkg::QUO_W-1:0]  quotient
);
    import trme_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= USEC_PER_MINUTE;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trme_pkg::*;

    // effect codes the package leaves out, and row values that mean "nothing"
    localparam logic [7:0] EFF_NONE   = 8'd0;
    localparam logic [7:0] EFF_END    = 8'd2;
    localparam logic [7:0] EFF_BREAK  = 8'd3;
    localparam logic [7:0] EFF_UNUSED = 8'd8;
    localparam logic [7:0] EFF_TOP    = 8'hFF;
    localparam logic [7:0] NOTE_NONE  = 8'd0;

    localparam int IDLE_PCT      = 23;
    localparam int SETTLE_CYCLES = 40;          // settling margin after the expected bytes drain
    localparam int HOLD_CYCLES   = 300;         // long receiver hold-off
    localparam int LIMIT_NS      = 5_000_000;   // many times the slowest clean run

    logic clk;
    logic rst_n;

    trme_row_if  row_if();
    trme_byte_if midi_if();
    trme_cfg_if  cfg_if();

    tracker_row_to_midi_events dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .row   (row_if),
        .midi  (midi_if)
    );

    // ------------------------------------------------------------------
    // predictor state: what the encoder should hold after each transaction
    // ------------------------------------------------------------------
    logic [7:0]        held_note;
    logic [TIME_W-1:0] event_time;
    logic [3:0]        chan_cfg;
    logic [9:0]        bpm_cfg;

    // expected midi bytes, oldest first
    out_item_t midi_expect[$];

    // stimulus bookkeeping
    logic [TIME_W-1:0] stim_time;
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int rows_sent      = 0;
    int flushes_sent   = 0;
    int bytes_checked  = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;

    // free-running clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #LIMIT_NS;
        $display("FAIL tracker_row_to_midi_events");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction: turns one accepted row or flush into its byte sequence
    // ------------------------------------------------------------------
    function automatic void predict_midi_bytes(input in_item_t it);
        logic [7:0]        fx_q[$];
        logic [7:0]        note_q[$];
        logic [7:0]        seq[$];
        logic [TIME_W-1:0] delta;
        logic [23:0]       tempo;
        int                bpm;
        int                quo;
        out_item_t         ob;
        if (it.operation == OP_FLUSH)
        begin
            // flush only turns off the sounding note, then closes the track
            if (held_note != NO_NOTE)
            begin
                note_q.push_back({STAT_NOTE_OFF, chan_cfg});
                note_q.push_back(held_note);
                note_q.push_back(8'h00);
                held_note = NO_NOTE;
            end
        end
        else
        begin
            // note first, so a note-off effect on the same row names the new note
            if (it.note_code != NOTE_NONE && it.note_code != NO_NOTE)
            begin
                if (held_note != NO_NOTE)
                begin
                    note_q.push_back({STAT_NOTE_OFF, chan_cfg});
                    note_q.push_back(held_note);
                    note_q.push_back(8'h00);
                    note_q.push_back(8'h00);
                end
                note_q.push_back({STAT_NOTE_ON, chan_cfg});
                note_q.push_back(it.note_code - 8'd1);
                note_q.push_back({1'b0, it.velocity});
                held_note = it.note_code - 8'd1;
            end
            case (it.effect_code)
                EFF_NOTE_OFF:
                begin
                    if (held_note != NO_NOTE)
                    begin
                        fx_q.push_back({STAT_NOTE_OFF, chan_cfg});
                        fx_q.push_back(held_note);
                        fx_q.push_back(8'h00);
                        held_note = NO_NOTE;
                    end
                end
                EFF_TEMPO_UP, EFF_TEMPO_DOWN, EFF_TEMPO_TWICE, EFF_TEMPO_HALF:
                begin
                    case (it.effect_code)
                        EFF_TEMPO_UP:    bpm = int'(bpm_cfg) + int'(it.effect_value);
                        EFF_TEMPO_DOWN:  bpm = int'(bpm_cfg) - int'(it.effect_value);
                        EFF_TEMPO_TWICE: bpm = int'(bpm_cfg) * 2;
                        default:         bpm = int'(bpm_cfg) / 2;
                    endcase
                    // zero or negative divisor, or a quotient past 24 bits, saturates
                    if (bpm <= 0)
                        tempo = TEMPO_MAX;
                    else
                    begin
                        quo = int'(USEC_PER_MINUTE) / bpm;
                        if (quo > int'(TEMPO_MAX))
                            tempo = TEMPO_MAX;
                        else
                            tempo = quo[23:0];
                    end
                    fx_q.push_back(META_STATUS);
                    fx_q.push_back(META_TEMPO);
                    fx_q.push_back(META_TEMPO_LEN);
                    fx_q.push_back(tempo[23:16]);
                    fx_q.push_back(tempo[15:8]);
                    fx_q.push_back(tempo[7:0]);
                end
                EFF_PROGRAM:
                begin
                    fx_q.push_back({STAT_PROGRAM, chan_cfg});
                    fx_q.push_back(it.effect_value);
                end
                default:
                begin
                end
            endcase
        end

        if (fx_q.size() + note_q.size() > 0)
        begin
            // delta time as a big-endian variable-length quantity, mod 2^28
            delta      = it.beat_time - event_time;
            event_time = it.beat_time;
            if (delta >= 28'h0200000)
                seq.push_back({1'b1, delta[27:21]});
            if (delta >= 28'h0004000)
                seq.push_back({1'b1, delta[20:14]});
            if (delta >= 28'h0000080)
                seq.push_back({1'b1, delta[13:7]});
            seq.push_back({1'b0, delta[6:0]});
            foreach (fx_q[i])
                seq.push_back(fx_q[i]);
            // zero delta between an effect event and a following note event
            if (fx_q.size() > 0 && note_q.size() > 0)
                seq.push_back(8'h00);
            foreach (note_q[i])
                seq.push_back(note_q[i]);
        end
        if (it.operation == OP_FLUSH)
        begin
            seq.push_back(8'h00);
            seq.push_back(META_STATUS);
            seq.push_back(META_EOT);
            seq.push_back(8'h00);
        end

        // a silent row queues nothing
        foreach (seq[i])
        begin
            ob.midi_byte = seq[i];
            ob.last_byte = (i == seq.size() - 1);
            midi_expect.push_back(ob);
        end
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic in_item_t row_item(input logic [TIME_W-1:0] t, input logic [7:0] note,
                                          input logic [6:0] vel, input logic [7:0] eff,
                                          input logic [7:0] val);
        in_item_t it;
        it.operation    = OP_ROW;
        it.beat_time    = t;
        it.note_code    = note;
        it.velocity     = vel;
        it.effect_code  = eff;
        it.effect_value = val;
        stim_time       = t;
        return it;
    endfunction

    // flush carries junk in every field but the operation and the time
    function automatic in_item_t flush_item(input logic [TIME_W-1:0] t);
        in_item_t it;
        it.operation    = OP_FLUSH;
        it.beat_time    = t;
        it.note_code    = 8'($urandom_range(0, 255));
        it.velocity     = 7'($urandom_range(0, 127));
        it.effect_code  = 8'($urandom_range(0, 255));
        it.effect_value = 8'($urandom_range(0, 255));
        stim_time       = t;
        return it;
    endfunction

    // mostly well-formed song rows moving forward in time, some jumps and flushes
    function automatic in_item_t random_item();
        in_item_t it;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            stim_time += TIME_W'($urandom_range(0, 127));
        else if (roll < 70)
            stim_time += TIME_W'($urandom_range(128, 16383));
        else if (roll < 82)
            stim_time += TIME_W'($urandom_range(16384, 2097151));
        else if (roll < 90)
            stim_time += TIME_W'($urandom_range(2097152, 268435455));
        else
            stim_time = TIME_W'($urandom_range(0, 268435455));

        if ($urandom_range(0, 99) < 6)
            return flush_item(stim_time);

        it.operation    = OP_ROW;
        it.beat_time    = stim_time;
        it.velocity     = 7'($urandom_range(0, 127));
        it.effect_value = 8'($urandom_range(0, 255));

        roll = $urandom_range(0, 99);
        if (roll < 70)
            it.note_code = 8'($urandom_range(1, 254));
        else if (roll < 80)
            it.note_code = NOTE_NONE;
        else if (roll < 88)
            it.note_code = NO_NOTE;
        else
            it.note_code = 8'($urandom_range(0, 255));

        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            case ($urandom_range(0, 2))
                0:       it.effect_code = EFF_NONE;
                1:       it.effect_code = EFF_UNUSED;
                default: it.effect_code = 8'($urandom_range(10, 255));
            endcase
        end
        else if (roll < 40)
            it.effect_code = EFF_NOTE_OFF;
        else if (roll < 46)
            it.effect_code = ($urandom_range(0, 1) == 0) ? EFF_END : EFF_BREAK;
        else if (roll < 78)
            it.effect_code = 8'($urandom_range(EFF_TEMPO_UP, EFF_TEMPO_HALF));
        else
            it.effect_code = EFF_PROGRAM;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one row transaction; returns at the accepting edge with valid still up,
    // so back-to-back items keep valid high
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            row_if.valid <= 1'b0;
            @(negedge clk);
        end
        row_if.valid <= 1'b1;
        row_if.data  <= it;
        do
            @(posedge clk);
        while (!row_if.ready);
        predict_midi_bytes(it);
        if (it.operation == OP_FLUSH)
            flushes_sent++;
        else
            rows_sent++;
    endtask

    // register write; only called while the encoder is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_VAL_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.value <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == CFG_CHANNEL)
            chan_cfg = val[3:0];
        else if (idx == CFG_TEMPO)
            bpm_cfg = val[9:0];
        cfg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid, let every expected byte drain, then allow for rows still in flight
    task automatic wait_idle();
        @(negedge clk);
        row_if.valid <= 1'b0;
        while (midi_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // byte sink: random stalls, or a counted hold-off when asked for one
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            midi_if.ready <= 1'b0;
            hold_left--;
        end
        else
            midi_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // checks each byte transaction against the oldest expectation
    always @(posedge clk)
    begin : check_bytes
        out_item_t want;
        if (rst_n && midi_if.valid && midi_if.ready)
        begin
            if (midi_expect.size() == 0)
            begin
                $display("%0t: unexpected midi byte %02h (last %0b), nothing expected",
                         $time, midi_if.data.midi_byte, midi_if.data.last_byte);
                mismatches++;
            end
            else
            begin
                want = midi_expect.pop_front();
                if (midi_if.data.midi_byte !== want.midi_byte)
                begin
                    $display("%0t: midi_byte mismatch, expected %02h, actual %02h",
                             $time, want.midi_byte, midi_if.data.midi_byte);
                    mismatches++;
                end
                if (midi_if.data.last_byte !== want.last_byte)
                begin
                    $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                             $time, want.last_byte, midi_if.data.last_byte);
                    mismatches++;
                end
                bytes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset tempo and channel; delta lengths of 1 to 4 bytes and time wrap
    task automatic test_reset_tempo_and_delta();
        send_item(row_item(28'd0, NOTE_NONE, 7'd0, EFF_TEMPO_UP, 8'd0));
        send_item(row_item(28'd127, 8'd1, 7'd0, EFF_NONE, 8'd0));
        send_item(row_item(28'd255, 8'd254, 7'd127, EFF_NONE, 8'd0));
        send_item(row_item(28'd16639, NO_NOTE, 7'd0, EFF_PROGRAM, 8'd0));
        send_item(row_item(28'd16639 + 28'h0200000, NOTE_NONE, 7'd0, EFF_PROGRAM, 8'hFF));
        send_item(row_item(28'hFFFFFFF, 8'd60, 7'd64, EFF_NONE, 8'd0));
        // time going backwards wraps modulo 2^28
        send_item(row_item(28'd5, 8'd61, 7'd100, EFF_NONE, 8'd0));
    endtask

    // rows that make no event leave time alone; end and break pass the note
    task automatic test_note_range_and_silence();
        send_item(row_item(28'd10, NOTE_NONE, 7'd127, EFF_NONE, 8'd0));
        send_item(row_item(28'd11, NO_NOTE, 7'd127, EFF_UNUSED, 8'd7));
        send_item(row_item(28'd12, NOTE_NONE, 7'd0, EFF_TOP, 8'hFF));
        send_item(row_item(28'd13, NOTE_NONE, 7'd0, EFF_BREAK, 8'd9));
        send_item(row_item(28'd14, 8'd40, 7'd1, EFF_END, 8'd0));
    endtask

    // note-off with and without a sounding note, same-row note-off, tempo forms
    task automatic test_effects();
        send_item(row_item(28'd20, NOTE_NONE, 7'd0, EFF_NOTE_OFF, 8'd0));
        send_item(row_item(28'd21, NOTE_NONE, 7'd0, EFF_NOTE_OFF, 8'd0));
        send_item(row_item(28'd30, 8'd70, 7'd90, EFF_NOTE_OFF, 8'd0));
        send_item(row_item(28'd31, 8'd71, 7'd90, EFF_NONE, 8'd0));
        send_item(row_item(28'd40, 8'd72, 7'd90, EFF_NOTE_OFF, 8'd0));
        // tempo down past zero saturates
        send_item(row_item(28'd50, NOTE_NONE, 7'd0, EFF_TEMPO_DOWN, 8'hFF));
        send_item(row_item(28'd51, NOTE_NONE, 7'd0, EFF_TEMPO_TWICE, 8'd0));
        send_item(row_item(28'd52, NOTE_NONE, 7'd0, EFF_TEMPO_HALF, 8'd0));
    endtask

    // slowest and fastest base tempo, top channel, and the longest row
    task automatic test_tempo_extremes();
        wait_idle();
        write_reg(CFG_TEMPO, 10'd1);
        write_reg(CFG_CHANNEL, 10'd15);
        // quotient too large, then a halved divisor of zero
        send_item(row_item(28'd60, NOTE_NONE, 7'd0, EFF_TEMPO_UP, 8'd0));
        send_item(row_item(28'd61, NOTE_NONE, 7'd0, EFF_TEMPO_HALF, 8'd0));
        wait_idle();
        write_reg(CFG_TEMPO, 10'd1023);
        send_item(row_item(28'd62, 8'd100, 7'd127, EFF_TEMPO_TWICE, 8'd0));
        // 4-byte delta + tempo + zero delta + note-off/note-on pair
        send_item(row_item(28'd62 + 28'h0200005, 8'd101, 7'd127, EFF_TEMPO_UP, 8'hFF));
    endtask

    // flush with a sounding note, then with none
    task automatic test_flush();
        send_item(flush_item(stim_time + 28'd96));
        send_item(flush_item(stim_time + 28'd3));
    endtask

    // shared body of the random phases
    task automatic random_phase(input logic [3:0] ch, input logic [9:0] bpm,
                                input int count, input bit idles);
        wait_idle();
        idle_on = idles;
        write_reg(CFG_CHANNEL, {6'd0, ch});
        write_reg(CFG_TEMPO, bpm);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_random_reset_config();
        random_phase(4'd0, TEMPO_RESET, 75, 1'b1);
    endtask

    task automatic test_random_max_config();
        random_phase(4'd15, 10'd1023, 60, 1'b1);
    endtask

    task automatic test_random_slow_tempo();
        random_phase(4'($urandom_range(0, 15)), 10'd1, 55, 1'b1);
    endtask

    // no idling on either side for a whole phase
    task automatic test_burst_no_idle();
        random_phase(4'($urandom_range(0, 15)), 10'($urandom_range(1, 1023)), 50, 1'b0);
    endtask

    // receiver holds off while rows keep coming, so the row input backs up
    task automatic test_backpressure();
        wait_idle();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_item(random_item());
        wait_idle();
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        row_if.valid  = 1'b0;
        row_if.data   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.value  = '0;

        // predictor starts from the reset state
        held_note  = NO_NOTE;
        event_time = '0;
        chan_cfg   = 4'd0;
        bpm_cfg    = TEMPO_RESET;
        stim_time  = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_tempo_and_delta();
        test_note_range_and_silence();
        test_effects();
        test_tempo_extremes();
        test_flush();
        test_random_reset_config();
        test_random_max_config();
        test_random_slow_tempo();
        test_burst_no_idle();
        test_backpressure();
        wait_idle();

        $display("ran %0d rows and %0d flushes over %0d register writes",
                 rows_sent, flushes_sent, cfg_writes);
        $display("compared %0d midi bytes, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0)
            $display("PASS tracker_row_to_midi_events");
        else
            $display("FAIL tracker_row_to_midi_events");
        $finish;
    end

endmodule
